// ===== hw/rtl/lfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfd_pkg: shared types and constants of the LED frame deframer
// Holds the header byte codes, the register reset value and the result
// record that travels from the parser to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfd_pkg;

  // Preamble characters and check byte mask
  localparam logic [7:0] PreambleA  = 8'h41;  // 'A'
  localparam logic [7:0] PreambleD  = 8'h64;  // 'd'
  localparam logic [7:0] PreambleA2 = 8'h61;  // 'a'
  localparam logic [7:0] CheckMask  = 8'h55;

  // Strip length register
  localparam int unsigned StripLenWidth = 9;
  localparam logic [StripLenWidth-1:0] StripLenReset = 9'd234;

  // Result of one byte
  typedef struct packed {
    logic       write_valid;
    logic [7:0] led_index;
    logic [1:0] channel;
    logic [7:0] channel_value;
    logic       frame_end;
    logic       header_good;
    logic       header_bad;
    logic       overrun;
  } lfd_result_t;

endpackage

// ===== hw/rtl/lfd_in_if.sv =====
// ----------------------------------------------------------------------------
// lfd_in_if: received byte channel
// Valid/ready channel carrying one serial byte and a parser restart flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
  modport mon    (input valid, input data_byte, input restart, input ready);
endinterface

// ===== hw/rtl/lfd_out_if.sv =====
// ----------------------------------------------------------------------------
// lfd_out_if: parse result channel
// Valid/ready channel carrying one colour-channel write and header status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lfd_out_if;
  logic       valid;
  logic       ready;
  logic       write_valid;
  logic [7:0] led_index;
  logic [1:0] channel;
  logic [7:0] channel_value;
  logic       frame_end;
  logic       header_good;
  logic       header_bad;
  logic       overrun;

  modport source (output valid, output write_valid, output led_index, output channel,
                  output channel_value, output frame_end, output header_good,
                  output header_bad, output overrun, input ready);
  modport sink   (input valid, input write_valid, input led_index, input channel,
                  input channel_value, input frame_end, input header_good,
                  input header_bad, input overrun, output ready);
  modport mon    (input valid, input write_valid, input led_index, input channel,
                  input channel_value, input frame_end, input header_good,
                  input header_bad, input overrun, input ready);
endinterface

// ===== hw/rtl/lfd_parser.sv =====
// ----------------------------------------------------------------------------
// lfd_parser: frame header and payload parser
// Holds the parse state and decodes one byte per transaction into a result
// record. The state advances only when a byte is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfd_parser #(
  parameter int unsigned MAX_LEDS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 advance,
  input  logic [7:0]                           data_byte,
  input  logic                                 restart,
  input  logic [lfd_pkg::StripLenWidth-1:0]    strip_length,
  output lfd_pkg::lfd_result_t                 result
);
  import lfd_pkg::*;

  typedef enum logic [2:0] {
    PH_A   = 3'd0,
    PH_D   = 3'd1,
    PH_A2  = 3'd2,
    PH_HI  = 3'd3,
    PH_LO  = 3'd4,
    PH_CHK = 3'd5,
    PH_PAY = 3'd6
  } phase_t;

  localparam logic [15:0] MaxLedsW = 16'(MAX_LEDS);

  phase_t      phase_r,   phase_nxt;
  logic [7:0]  cnt_hi_r,  cnt_hi_nxt;
  logic [7:0]  cnt_lo_r,  cnt_lo_nxt;
  logic [17:0] left_r,    left_nxt;
  logic [15:0] pixel_r,   pixel_nxt;
  logic [1:0]  slot_r,    slot_nxt;

  logic [15:0] limit;
  logic [15:0] strip_w;
  logic [15:0] count;
  logic [17:0] count3;

  // Clamp the strip length to the fitted maximum
  assign strip_w = 16'(strip_length);
  assign limit   = (strip_w > MaxLedsW) ? MaxLedsW : strip_w;
  assign count   = {cnt_hi_r, cnt_lo_r};
  assign count3  = {1'b0, count, 1'b0} + {2'b00, count};

  // Decode the byte and work out the next parse state
  always_comb begin
    result     = '0;
    phase_nxt  = phase_r;
    cnt_hi_nxt = cnt_hi_r;
    cnt_lo_nxt = cnt_lo_r;
    left_nxt   = left_r;
    pixel_nxt  = pixel_r;
    slot_nxt   = slot_r;

    if (restart) begin
      phase_nxt  = PH_A;
      cnt_hi_nxt = '0;
      cnt_lo_nxt = '0;
      left_nxt   = '0;
      pixel_nxt  = '0;
      slot_nxt   = '0;
    end else begin
      unique case (phase_r)
        PH_D: begin
          phase_nxt = (data_byte == PreambleD) ? PH_A2 : PH_A;
        end
        PH_A2: begin
          phase_nxt = (data_byte == PreambleA2) ? PH_HI : PH_A;
        end
        PH_HI: begin
          cnt_hi_nxt = data_byte;
          phase_nxt  = PH_LO;
        end
        PH_LO: begin
          cnt_lo_nxt = data_byte;
          phase_nxt  = PH_CHK;
        end
        PH_CHK: begin
          if (data_byte == (cnt_hi_r ^ cnt_lo_r ^ CheckMask)) begin
            result.header_good = 1'b1;
            pixel_nxt          = '0;
            slot_nxt           = '0;
            // an empty frame ends on its check byte
            if (count == '0) begin
              result.frame_end = 1'b1;
              left_nxt         = '0;
              phase_nxt        = PH_A;
            end else begin
              left_nxt  = count3;
              phase_nxt = PH_PAY;
            end
          end else begin
            result.header_bad = 1'b1;
            phase_nxt         = PH_A;
          end
        end
        PH_PAY: begin
          if (pixel_r < limit) begin
            result.write_valid   = 1'b1;
            result.led_index     = pixel_r[7:0];
            result.channel       = slot_r;
            result.channel_value = data_byte;
          end else begin
            result.overrun = 1'b1;
          end
          // step colour slot, then LED position
          if (slot_r >= 2'd2) begin
            slot_nxt  = '0;
            pixel_nxt = pixel_r + 16'd1;
          end else begin
            slot_nxt = slot_r + 2'd1;
          end
          if (left_r != '0) begin
            left_nxt = left_r - 18'd1;
          end
          if (left_nxt == '0) begin
            result.frame_end = 1'b1;
            phase_nxt        = PH_A;
          end
        end
        default: begin
          // preamble search; the unused code behaves the same
          phase_nxt = (data_byte == PreambleA) ? PH_D : PH_A;
        end
      endcase
    end
  end

  // Hold parse state; advance on each taken byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_A;
      cnt_hi_r <= '0;
      cnt_lo_r <= '0;
      left_r   <= '0;
      pixel_r  <= '0;
      slot_r   <= '0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      cnt_hi_r <= cnt_hi_nxt;
      cnt_lo_r <= cnt_lo_nxt;
      left_r   <= left_nxt;
      pixel_r  <= pixel_nxt;
      slot_r   <= slot_nxt;
    end
  end

endmodule

// ===== hw/rtl/led_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// led_frame_deframer_top: serial LED frame deframer
// Parses preamble, count and check byte, then streams payload bytes out as
// colour-channel writes tagged with LED index and colour slot.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one received byte per transaction plus a restart flag that
//   clears the parser (the byte is then ignored and an all-zero result goes
//   out). out_ch carries exactly one result per input byte, in order.
//   cfg_we/cfg_data write the strip length; write it only while idle.
// Timing:
//   The byte is decoded by the parser against its state registers and the
//   result lands in the output register in the next cycle.
//   Throughput is one byte per cycle; the output register is the only
//   stage, so in_ch.ready stays high while that register is empty or
//   being drained by out_ch.ready in the same cycle.
// Reset:
//   Synchronous on rst_n low: parser back to preamble search, output
//   register empty, strip length 234.
// Stall:
//   With out_ch.ready low and a result held, in_ch.ready drops and the
//   parser holds its state; the held result stays stable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_frame_deframer_top #(
  parameter int unsigned MAX_LEDS = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  lfd_in_if.sink                            in_ch,
  lfd_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [lfd_pkg::StripLenWidth-1:0] cfg_data
);
  import lfd_pkg::*;

  logic [StripLenWidth-1:0] strip_len_r;
  logic                     out_valid_r;
  lfd_result_t              out_res_r;
  lfd_result_t              result;
  logic                     in_take;

  // Accept while the output register is empty or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Hold strip length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_len_r <= StripLenReset;
    end else if (cfg_we) begin
      strip_len_r <= cfg_data;
    end
  end

  lfd_parser #(
    .MAX_LEDS (MAX_LEDS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (in_take),
    .data_byte    (in_ch.data_byte),
    .restart      (in_ch.restart),
    .strip_length (strip_len_r),
    .result       (result)
  );

  // Load the result register on each input transaction, drop it when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_res_r <= result;
    end
  end

  // Drive the result channel
  assign out_ch.valid         = out_valid_r;
  assign out_ch.write_valid   = out_res_r.write_valid;
  assign out_ch.led_index     = out_res_r.led_index;
  assign out_ch.channel       = out_res_r.channel;
  assign out_ch.channel_value = out_res_r.channel_value;
  assign out_ch.frame_end     = out_res_r.frame_end;
  assign out_ch.header_good   = out_res_r.header_good;
  assign out_ch.header_bad    = out_res_r.header_bad;
  assign out_ch.overrun       = out_res_r.overrun;

endmodule

// ===== hw/rtl/lfd_checker.sv =====
// ----------------------------------------------------------------------------
// lfd_checker: port-level checks of the LED frame deframer
// Watches the top level's channels and flags broken handshake timing and
// inconsistent result flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfd_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_restart,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_write_valid,
  input  logic [7:0] out_led_index,
  input  logic [1:0] out_channel,
  input  logic [7:0] out_channel_value,
  input  logic       out_frame_end,
  input  logic       out_header_good,
  input  logic       out_header_bad,
  input  logic       out_overrun
);

  // Result register is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Input side is never stalled while no result is held
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // A taken restart yields an all-zero result next cycle
  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_restart |=>
      out_valid && !out_write_valid && !out_frame_end &&
      !out_header_good && !out_header_bad && !out_overrun &&
      out_led_index == '0 && out_channel == '0 && out_channel_value == '0)
    else $error("restart produced a nonzero result");

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_channel_value) && $stable(out_frame_end))
    else $error("stalled result changed");

  // Write, overrun and header status never mix on one result
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=>
      $onehot0({out_write_valid, out_overrun, out_header_good, out_header_bad}))
    else $error("conflicting result flags");

endmodule

bind led_frame_deframer_top lfd_checker u_lfd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_restart        (in_ch.restart),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_write_valid   (out_ch.write_valid),
  .out_led_index     (out_ch.led_index),
  .out_channel       (out_ch.channel),
  .out_channel_value (out_ch.channel_value),
  .out_frame_end     (out_ch.frame_end),
  .out_header_good   (out_ch.header_good),
  .out_header_bad    (out_ch.header_bad),
  .out_overrun       (out_ch.overrun)
);
